### src/ascfd_pkg.sv
package ascfd_pkg;

  // Frame layout
  localparam int unsigned CHANNELS_DEFAULT = 8;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned WORD_W           = 24;
  localparam int unsigned SLOT_W           = 4;
  localparam int unsigned PHASE_W          = 2;

  // Status word check: top nibble must read 0xC
  localparam logic [3:0] STATUS_NIBBLE_OK = 4'hC;

  // Byte position within a word
  localparam logic [PHASE_W-1:0] PHASE_FIRST = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 2'd2;

endpackage

### src/adc_status_channel_frame_deframer.sv
// Channel  Handshake                   Payload
// -------  --------------------------  ------------------------------------------------
// in       in_valid / in_stall         data_byte[7:0], frame_start
// out      out_valid / out_stall       slot[3:0], status_word[23:0], sample[23:0] (signed),
//                                      header_ok, last_of_frame
//
// One byte per cycle is taken while in_stall is low; every third byte of a word loads the result register,
// so a word appears at out in the cycle after its last byte is accepted.
// The only throughput limit is the single result register: in_stall is raised only
// while a result is held and out_stall is high.
// rst (synchronous, active high) clears the byte and slot counters, the header flag
// and out_valid; the first byte after reset is taken as byte 0 of a status word.
module adc_status_channel_frame_deframer #(
  parameter int unsigned CHANNELS = ascfd_pkg::CHANNELS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // request in
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ascfd_pkg::BYTE_W-1:0]          data_byte,
  input  logic                                  frame_start,
  // request out
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ascfd_pkg::SLOT_W-1:0]          slot,
  output logic [ascfd_pkg::WORD_W-1:0]          status_word,
  output logic signed [ascfd_pkg::WORD_W-1:0]   sample,
  output logic                                  header_ok,
  output logic                                  last_of_frame
);

  localparam logic [ascfd_pkg::SLOT_W-1:0] LAST_SLOT = ascfd_pkg::SLOT_W'(CHANNELS);
  localparam int unsigned PART_W = ascfd_pkg::WORD_W - ascfd_pkg::BYTE_W;

  // Frame tracking state
  logic [ascfd_pkg::PHASE_W-1:0] byte_phase;
  logic [ascfd_pkg::SLOT_W-1:0]  word_slot;
  logic [PART_W-1:0]             partial_word;
  logic                          frame_header_valid;

  logic [ascfd_pkg::PHASE_W-1:0] byte_phase_next;
  logic [ascfd_pkg::SLOT_W-1:0]  word_slot_next;
  logic [PART_W-1:0]             partial_word_next;
  logic                          frame_header_valid_next;

  logic                          in_accept;
  logic                          out_accept;
  logic [ascfd_pkg::PHASE_W-1:0] phase_eff;
  logic [ascfd_pkg::SLOT_W-1:0]  slot_eff;
  logic                          word_done;
  logic [ascfd_pkg::WORD_W-1:0]  word;
  logic                          nibble_ok;

  // Handshake: hold input only while a result is stuck
  assign in_stall   = out_valid && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // frame_start realigns counters before this byte
  assign phase_eff = frame_start ? ascfd_pkg::PHASE_FIRST : byte_phase;
  assign slot_eff  = frame_start ? '0 : word_slot;
  assign word_done = (phase_eff == ascfd_pkg::PHASE_LAST);
  assign word      = {partial_word, data_byte};
  assign nibble_ok = (word[ascfd_pkg::WORD_W-1 -: 4] == ascfd_pkg::STATUS_NIBBLE_OK);

  // Next-state logic
  always_comb begin
    byte_phase_next         = byte_phase;
    word_slot_next          = word_slot;
    partial_word_next       = partial_word;
    frame_header_valid_next = frame_header_valid;
    if (in_accept) begin
      if (!word_done) begin
        byte_phase_next   = phase_eff + 1'b1;
        word_slot_next    = slot_eff;
        partial_word_next = {partial_word[PART_W-ascfd_pkg::BYTE_W-1:0], data_byte};
      end else begin
        byte_phase_next   = ascfd_pkg::PHASE_FIRST;
        partial_word_next = '0;
        word_slot_next    = (slot_eff >= LAST_SLOT) ? '0 : slot_eff + 1'b1;
        if (slot_eff == '0) begin
          frame_header_valid_next = nibble_ok;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase         <= ascfd_pkg::PHASE_FIRST;
      word_slot          <= '0;
      partial_word       <= '0;
      frame_header_valid <= 1'b0;
    end else begin
      byte_phase         <= byte_phase_next;
      word_slot          <= word_slot_next;
      partial_word       <= partial_word_next;
      frame_header_valid <= frame_header_valid_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && word_done) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (in_accept && word_done) begin
      slot          <= slot_eff;
      status_word   <= (slot_eff == '0) ? word : '0;
      sample        <= (slot_eff == '0) ? '0 : $signed(word);
      header_ok     <= frame_header_valid_next;
      last_of_frame <= (slot_eff == LAST_SLOT);
    end
  end

  // Checks
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    byte_phase != 2'd3)
    else $error("byte_phase out of range");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    word_slot <= LAST_SLOT)
    else $error("word_slot beyond channel count");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> slot == LAST_SLOT)
    else $error("last_of_frame on wrong slot");

  a_word_result: assert property (@(posedge clk) disable iff (rst)
    in_accept && word_done |=> out_valid && slot == $past(slot_eff))
    else $error("completed word did not produce a result");

  a_field_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((slot == '0) ? (sample == '0) : (status_word == '0)))
    else $error("unused result field not zero");

endmodule
